// File: design/vpvm_pkg.sv
package vpvm_pkg;

  localparam int NUM_REGS  = 7;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int COEF_W    = 21;
  localparam int PT_W      = 32;
  localparam int OFF_W     = 32;
  localparam int PROD_W    = PT_W + COEF_W;
  localparam int CLIP_W    = 56;
  localparam int SUM_W     = CLIP_W + 1;
  localparam int VP_W      = 16;
  localparam int NUM_W     = SUM_W + VP_W + 1;
  localparam int DEN_W     = CLIP_W + 1;
  localparam int QBITS     = 18;
  localparam int SCR_W     = 16;
  localparam int SUMS_W    = QBITS + 2;

  // accept edge to the edge that samples the result
  localparam int PIPE_LAT  = QBITS + 8;

  localparam logic [REG_IDX_W-1:0] REG_CLIP_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_Z   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_W   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OFF_XY   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OFF_ZW   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_VIEWPORT = 3'd6;

  localparam logic [CFG_W-1:0] RST_CLIP_X   = 64'd1024;
  localparam logic [CFG_W-1:0] RST_CLIP_Y   = 64'd2147483648;
  localparam logic [CFG_W-1:0] RST_CLIP_Z   = 64'd4503599627370496;
  localparam logic [CFG_W-1:0] RST_CLIP_W   = 64'd0;
  localparam logic [CFG_W-1:0] RST_OFF_XY   = 64'd0;
  localparam logic [CFG_W-1:0] RST_OFF_ZW   = 64'd281474976710656;
  localparam logic [CFG_W-1:0] RST_VIEWPORT = 64'd2450024368387620864;

  // 0.0001 in Q.26
  localparam logic signed [CLIP_W-1:0] W_MIN = 56'sd6711;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_W_SMALL  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic w_small;
    logic neg_x;
    logic neg_y;
    logic d_zero;
    logic d_full;
  } side_t;

endpackage

// File: design/vpvm_div.sv
module vpvm_div #(
  parameter int NW = vpvm_pkg::NUM_W,
  parameter int DW = vpvm_pkg::DEN_W,
  parameter int QB = vpvm_pkg::QBITS
) (
  input  logic          clk,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  output logic [QB-1:0] out_q,
  output logic          out_sat
);

  localparam int CW = DW + QB + 1;

  logic [CW-1:0] rem_r [QB+1];
  logic [DW-1:0] den_r [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          sat_r [QB+1];

  // entry: flag quotients that do not fit in QB bits
  always_ff @(posedge clk) begin
    rem_r[0] <= CW'(in_num);
    den_r[0] <= in_den;
    q_r[0]   <= '0;
    sat_r[0] <= CW'(in_num) >= (CW'(in_den) << QB);
  end

  // one restoring step per stage, MSB first
  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int SH = QB - 1 - k;
    logic [CW:0] trial;
    assign trial = {1'b0, rem_r[k]} - {1'b0, CW'(den_r[k]) << SH};
    always_ff @(posedge clk) begin
      den_r[k+1] <= den_r[k];
      sat_r[k+1] <= sat_r[k];
      if (!trial[CW]) begin
        rem_r[k+1] <= trial[CW-1:0];
        q_r[k+1]   <= q_r[k] | (QB'(1) << SH);
      end else begin
        rem_r[k+1] <= rem_r[k];
        q_r[k+1]   <= q_r[k];
      end
    end
  end

  assign out_q   = q_r[QB];
  assign out_sat = sat_r[QB];

endmodule

// File: design/vertex_projection_viewport_map_top.sv
// channel  | handshake           | ports
// ---------+---------------------+--------------------------------------------
// input    | start && !busy      | in_point_x, in_point_y, in_point_z
// result   | out_valid, 1 cycle  | out_status, out_screen_x, out_screen_y,
//          |                     | out_depth
// config   | cfg_we              | cfg_index, cfg_wdata
//
// One vertex per cycle; each taken beat yields one result on the ports.
// The pipeline is the six transform/multiply stages, the divider entry,
// the 18-stage restoring divider (one quotient bit per stage) and the
// output register.
// Reset is synchronous; busy is high during reset and low afterwards.
// The receiver cannot stall, so the pipeline never holds.
module vertex_projection_viewport_map_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [vpvm_pkg::PT_W-1:0] in_point_x,
  input  logic signed [vpvm_pkg::PT_W-1:0] in_point_y,
  input  logic signed [vpvm_pkg::PT_W-1:0] in_point_z,
  input  logic                          cfg_we,
  input  logic [vpvm_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [vpvm_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic signed [vpvm_pkg::SCR_W-1:0] out_screen_x,
  output logic signed [vpvm_pkg::SCR_W-1:0] out_screen_y,
  output logic [vpvm_pkg::SCR_W-1:0]     out_depth
);
  import vpvm_pkg::*;

  localparam int DLY = QBITS + 1;

  logic [CFG_W-1:0] cfg_r [NUM_REGS];
  logic             busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_CLIP_X]   <= RST_CLIP_X;
      cfg_r[REG_CLIP_Y]   <= RST_CLIP_Y;
      cfg_r[REG_CLIP_Z]   <= RST_CLIP_Z;
      cfg_r[REG_CLIP_W]   <= RST_CLIP_W;
      cfg_r[REG_OFF_XY]   <= RST_OFF_XY;
      cfg_r[REG_OFF_ZW]   <= RST_OFF_ZW;
      cfg_r[REG_VIEWPORT] <= RST_VIEWPORT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLIP_X, REG_CLIP_Y, REG_CLIP_Z, REG_CLIP_W:
          cfg_r[cfg_index] <= {1'b0, cfg_wdata[CFG_W-2:0]};
        REG_OFF_XY, REG_OFF_ZW, REG_VIEWPORT:
          cfg_r[cfg_index] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else        busy_r <= 1'b0;
  end
  assign busy = busy_r;

  logic signed [COEF_W-1:0] coef [4][3];
  logic signed [OFF_W-1:0]  off  [4];
  for (genvar r = 0; r < 4; r++) begin : g_coef
    for (genvar k = 0; k < 3; k++) begin : g_k
      assign coef[r][k] = signed'(cfg_r[r][COEF_W*k +: COEF_W]);
    end
    assign off[r] = signed'(cfg_r[REG_OFF_XY + REG_IDX_W'(r / 2)][OFF_W*(r % 2) +: OFF_W]);
  end

  logic [VP_W-1:0] vp_x, vp_y, vp_wd, vp_ht;
  assign vp_x  = cfg_r[REG_VIEWPORT][15:0];
  assign vp_y  = cfg_r[REG_VIEWPORT][31:16];
  assign vp_wd = cfg_r[REG_VIEWPORT][47:32];
  assign vp_ht = cfg_r[REG_VIEWPORT][63:48];

  // stage 0: input capture
  logic                   v0_r;
  logic signed [PT_W-1:0] pt_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start && !busy_r;
    pt_r[0] <= in_point_x;
    pt_r[1] <= in_point_y;
    pt_r[2] <= in_point_z;
  end

  // stage 1: twelve partial products
  logic                     v1_r;
  logic signed [PROD_W-1:0] prod_r [4][3];
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= v0_r;
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[r][k] <= pt_r[k] * coef[r][k];
      end
    end
  end

  // stage 2: clip coordinates, Q.26
  logic                     v2_r;
  logic signed [CLIP_W-1:0] clip_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    for (int r = 0; r < 4; r++) begin
      clip_r[r] <= CLIP_W'(prod_r[r][0]) + CLIP_W'(prod_r[r][1]) + CLIP_W'(prod_r[r][2])
                   + (CLIP_W'(off[r]) <<< 10);
    end
  end

  // stage 3: axis numerators, magnitudes and classification
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  assign sum_x = SUM_W'(clip_r[0]) + SUM_W'(clip_r[3]);
  assign sum_y = SUM_W'(clip_r[3]) - SUM_W'(clip_r[1]);

  logic                     v3_r;
  logic [SUM_W-1:0]         ax_r, ay_r;
  logic signed [CLIP_W-1:0] cz3_r, cw3_r;
  side_t                    sd3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    ax_r           <= sum_x[SUM_W-1] ? unsigned'(-sum_x) : unsigned'(sum_x);
    ay_r           <= sum_y[SUM_W-1] ? unsigned'(-sum_y) : unsigned'(sum_y);
    cz3_r          <= clip_r[2];
    cw3_r          <= clip_r[3];
    sd3_r.w_small  <= clip_r[3] <= W_MIN;
    sd3_r.neg_x    <= sum_x[SUM_W-1];
    sd3_r.neg_y    <= sum_y[SUM_W-1];
    sd3_r.d_zero   <= clip_r[2] <= CLIP_W'(0);
    sd3_r.d_full   <= clip_r[2] >= clip_r[3];
  end

  // stage 4: scale by viewport size
  logic             v4_r;
  logic [NUM_W-1:0] mx_r, my_r, dn4_r;
  logic [CLIP_W-1:0] w4_r;
  side_t            sd4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    mx_r  <= NUM_W'(ax_r) * NUM_W'(vp_wd);
    my_r  <= NUM_W'(ay_r) * NUM_W'(vp_ht);
    dn4_r <= NUM_W'(unsigned'(cz3_r)) << 16;
    w4_r  <= unsigned'(cw3_r);
    sd4_r <= sd3_r;
  end

  // stage 5: rounding bias, divisors
  logic             v5_r;
  logic [NUM_W-1:0] nx_r, ny_r, nd_r;
  logic [DEN_W-1:0] dxy_r, dd_r;
  side_t            sd5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
    nx_r  <= mx_r + NUM_W'(w4_r);
    ny_r  <= my_r + NUM_W'(w4_r);
    nd_r  <= dn4_r + NUM_W'(w4_r >> 1);
    dxy_r <= DEN_W'(w4_r) << 1;
    dd_r  <= DEN_W'(w4_r);
    sd5_r <= sd4_r;
  end

  logic [QBITS-1:0] qx, qy, qd;
  logic             satx, saty, satd;

  vpvm_div #(.NW(NUM_W), .DW(DEN_W), .QB(QBITS)) u_div_x (
    .clk(clk), .in_num(nx_r), .in_den(dxy_r), .out_q(qx), .out_sat(satx));
  vpvm_div #(.NW(NUM_W), .DW(DEN_W), .QB(QBITS)) u_div_y (
    .clk(clk), .in_num(ny_r), .in_den(dxy_r), .out_q(qy), .out_sat(saty));
  vpvm_div #(.NW(NUM_W), .DW(DEN_W), .QB(QBITS)) u_div_d (
    .clk(clk), .in_num(nd_r), .in_den(dd_r), .out_q(qd), .out_sat(satd));

  // side info rides alongside the divider stages
  logic  vd_r [DLY];
  side_t sdd_r [DLY];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DLY; i++) vd_r[i] <= 1'b0;
    end else begin
      vd_r[0] <= v5_r;
      for (int i = 1; i < DLY; i++) vd_r[i] <= vd_r[i-1];
    end
    sdd_r[0] <= sd5_r;
    for (int i = 1; i < DLY; i++) sdd_r[i] <= sdd_r[i-1];
  end

  // final stage: origin add, range checks, result select
  side_t                    sdf;
  logic signed [SUMS_W-1:0] sx, sy, qxs, qys;
  logic                     ovf;
  logic [SCR_W-1:0]         depth;
  assign sdf = sdd_r[DLY-1];
  assign qxs = signed'(SUMS_W'(qx));
  assign qys = signed'(SUMS_W'(qy));
  assign sx  = signed'(SUMS_W'(vp_x)) + (sdf.neg_x ? -qxs : qxs);
  assign sy  = signed'(SUMS_W'(vp_y)) + (sdf.neg_y ? -qys : qys);
  assign ovf = satx || saty
            || sx < -SUMS_W'(32768) || sx > SUMS_W'(32767)
            || sy < -SUMS_W'(32768) || sy > SUMS_W'(32767);

  always_comb begin
    if (sdf.d_zero)                       depth = '0;
    else if (sdf.d_full || satd || qd[QBITS-1:SCR_W] != '0) depth = '1;
    else                                  depth = qd[SCR_W-1:0];
  end

  logic                     out_valid_r;
  logic [1:0]               status_r;
  logic signed [SCR_W-1:0]  scr_x_r, scr_y_r;
  logic [SCR_W-1:0]         depth_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= vd_r[DLY-1];
    if (sdf.w_small) begin
      status_r <= ST_W_SMALL;
      scr_x_r  <= '0;
      scr_y_r  <= '0;
      depth_r  <= '0;
    end else if (ovf) begin
      status_r <= ST_OVERFLOW;
      scr_x_r  <= '0;
      scr_y_r  <= '0;
      depth_r  <= '0;
    end else begin
      status_r <= ST_OK;
      scr_x_r  <= sx[SCR_W-1:0];
      scr_y_r  <= sy[SCR_W-1:0];
      depth_r  <= depth;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_screen_x = scr_x_r;
  assign out_screen_y = scr_y_r;
  assign out_depth    = depth_r;

endmodule

// File: design/vpvm_chk.sv
module vpvm_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic [1:0]                       out_status,
  input logic signed [vpvm_pkg::SCR_W-1:0] out_screen_x,
  input logic signed [vpvm_pkg::SCR_W-1:0] out_screen_y,
  input logic [vpvm_pkg::SCR_W-1:0]        out_depth
);
  import vpvm_pkg::*;

  // every taken beat yields a result at the end of the pipeline
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("result missing after accepted beat");

  // no result without a matching earlier taken beat
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without matching beat");

  // rejected results carry zero payload
  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_screen_x == '0 && out_screen_y == '0 && out_depth == '0))
    else $error("rejected result with nonzero payload");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && busy))
    else $error("activity during reset");

endmodule

bind vertex_projection_viewport_map_top vpvm_chk u_vpvm_chk (.*);
